>>> rtl/euler_point_rotator_defines.svh
// ----------------------------------------------------------------------------
// Euler point rotator assertion macros
// Shared concurrent assertion forms for the rotator's checker.
// ----------------------------------------------------------------------------
`ifndef EULER_POINT_ROTATOR_DEFINES_SVH
`define EULER_POINT_ROTATOR_DEFINES_SVH

// Check a property at every clock edge while out of reset
`define EPR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("euler_point_rotator: assertion failed");

// Check a property at every clock edge, reset cycles included
`define EPR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("euler_point_rotator: assertion failed");

`endif

>>> rtl/epr_pkg.sv
// ----------------------------------------------------------------------------
// Euler point rotator package
// Widths, register indexes, types and fixed constants of the rotator.
// ----------------------------------------------------------------------------
package epr_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;

    // Configuration fields
    localparam int ZOOM_W = 8;
    localparam int SIZE_W = 11;
    localparam int CEN_W  = ZOOM_W + SIZE_W - 1;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_ZOOM   = 3'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [IDX_W-1:0] REG_YAW    = 3'd3;
    localparam logic [IDX_W-1:0] REG_PITCH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROLL   = 3'd5;

    // Q1.16 rotation coefficients, 18 bit signed, row major
    localparam int COEF_W = 18;
    localparam int NCOEF  = 9;
    localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sh10000;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [NCOEF-1:0][COEF_W-1:0] coef_mat_t;

    // Odd Taylor terms of the quarter-turn sine, Q2.30
    localparam logic signed [31:0] K1 = 32'sd1686629713;
    localparam logic signed [31:0] K3 = -32'sd693598671;
    localparam logic signed [31:0] K5 = 32'sd85569278;
    localparam logic signed [31:0] K7 = -32'sd5027044;
    localparam logic signed [31:0] K9 = 32'sd172272;

    // Horner term added after each multiply step, highest order first
    function automatic logic signed [31:0] horner_k(input logic [1:0] step);
        logic signed [31:0] k;
        unique case (step)
            2'd0: k = K7;
            2'd1: k = K5;
            2'd2: k = K3;
            2'd3: k = K1;
        endcase
        return k;
    endfunction

    // Byte-padded width of a three-coordinate beat
    function automatic int tdata_w(input int cb);
        return ((3 * cb + 7) / 8) * 8;
    endfunction

    // Configuration data width: the widest register
    function automatic int cfg_w(input int ab);
        return (ab > SIZE_W) ? ab : SIZE_W;
    endfunction

endpackage

>>> rtl/euler_point_rotator.sv
// ----------------------------------------------------------------------------
// Euler point rotator
// Rotates integer 3D points about the center of the zoomed map grid by a
// z-y-x Euler matrix held as nine Q1.16 coefficients.
//
//   channel   dir   payload                                  handshake
//   s_        in    point_x, point_y, point_z                tvalid/tready
//   m_        out   rotated_x, rotated_y, rotated_z          tvalid/tready
//   cfg_      in    register index, write data               valid/ready
//
// One point per cycle outside coefficient rebuilds; a point passes registered
// stages for the input difference, the nine parallel multiplies, and the row
// sums and saturation. A stalled m_ side holds the whole pipeline; s_tready
// drops with it. After reset and after every angle write the coefficients are
// rebuilt on one shared multiplier with s_tready low. Other writes take effect
// at once. Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module euler_point_rotator #(
    parameter int COORD_BITS = epr_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = epr_pkg::ANGLE_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // input points
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // point_x, point_y, point_z, zero pad
    input  logic [epr_pkg::tdata_w(COORD_BITS)-1:0]    s_tdata,
    // rotated points
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // rotated_x, rotated_y, rotated_z, zero pad
    output logic [epr_pkg::tdata_w(COORD_BITS)-1:0]    m_tdata,
    // configuration writes
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [epr_pkg::IDX_W-1:0]                  cfg_index,
    input  logic [epr_pkg::cfg_w(ANGLE_BITS)-1:0]      cfg_data
);
    import epr_pkg::*;

    localparam int TDW = tdata_w(COORD_BITS);
    localparam int DW  = ((COORD_BITS > CEN_W) ? COORD_BITS : CEN_W) + 2;
    localparam int PW  = COEF_W + DW;
    localparam int SW  = PW + 2;
    localparam int QW  = SW - 16;
    localparam logic signed [QW-1:0] OUT_HI =
        {{(QW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [QW-1:0] OUT_LO =
        {{(QW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    // Configuration registers
    logic [ZOOM_W-1:0]     zoom_reg;
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [ANGLE_BITS-1:0] yaw_reg;
    logic [ANGLE_BITS-1:0] pitch_reg;
    logic [ANGLE_BITS-1:0] roll_reg;

    // Pipeline
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  m_tvalid_reg;
    logic signed [DW-1:0]  d_reg [3];
    logic signed [DW-1:0]  d_next [3];
    logic signed [PW-1:0]  prod_reg [NCOEF];
    logic signed [PW-1:0]  prod_next [NCOEF];
    logic [TDW-1:0]        m_tdata_reg;
    logic [TDW-1:0]        m_tdata_next;

    logic                  cfg_fire;
    logic                  angle_wr;
    logic                  adv;
    logic                  s_accept;
    logic                  busy;
    coef_mat_t             coef;
    logic [CEN_W:0]        cx_full;
    logic [CEN_W:0]        cy_full;
    logic [SIZE_W-1:0]     wm1;
    logic [SIZE_W-1:0]     hm1;
    logic [CEN_W-1:0]      cen_row [3];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign angle_wr  = cfg_fire && (cfg_index == REG_YAW || cfg_index == REG_PITCH ||
                                    cfg_index == REG_ROLL);

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg   <= ZOOM_W'(1);
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
            yaw_reg    <= '0;
            pitch_reg  <= '0;
            roll_reg   <= '0;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_ZOOM:   zoom_reg   <= cfg_data[ZOOM_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_YAW:    yaw_reg    <= cfg_data[ANGLE_BITS-1:0];
                REG_PITCH:  pitch_reg  <= cfg_data[ANGLE_BITS-1:0];
                REG_ROLL:   roll_reg   <= cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Grid center: zoom * (size - 1) / 2, a size of zero counts as one
    assign wm1     = (width_reg == '0) ? '0 : width_reg - SIZE_W'(1);
    assign hm1     = (height_reg == '0) ? '0 : height_reg - SIZE_W'(1);
    assign cx_full = {{SIZE_W{1'b0}}, zoom_reg} * {{ZOOM_W{1'b0}}, wm1};
    assign cy_full = {{SIZE_W{1'b0}}, zoom_reg} * {{ZOOM_W{1'b0}}, hm1};

    assign cen_row[0] = cx_full[CEN_W:1];
    assign cen_row[1] = cy_full[CEN_W:1];
    assign cen_row[2] = '0;

    // Coefficient builder
    epr_matrix #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (angle_wr),
        .yaw     (yaw_reg),
        .pitch   (pitch_reg),
        .roll    (roll_reg),
        .busy    (busy),
        .coef    (coef)
    );

    // Pipeline advances unless a result is waiting on a stalled sink
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && !busy;
    assign s_accept = s_tvalid && s_tready;

    // Stage 1: offset the point by the center
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            d_next[c] = $signed({{(DW-COORD_BITS){s_tdata[c*COORD_BITS+COORD_BITS-1]}},
                                 s_tdata[c*COORD_BITS +: COORD_BITS]})
                      - $signed({{(DW-CEN_W){1'b0}}, cen_row[c]});
        end
    end

    // Stage 2: nine coefficient products
    always_comb begin
        for (int i = 0; i < NCOEF; i++) begin
            prod_next[i] = $signed(coef[i]) * d_reg[i % 3];
        end
    end

    // Stage 3: row sums, truncate toward zero, saturate
    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] biased;
        logic signed [QW-1:0] quo;
        m_tdata_next = '0;
        for (int r = 0; r < 3; r++) begin
            acc = SW'(prod_reg[3*r]) + SW'(prod_reg[3*r+1]) + SW'(prod_reg[3*r+2])
                + $signed({{(SW-CEN_W-16){1'b0}}, cen_row[r], 16'h0000});
            biased = acc + (acc[SW-1] ? SW'(65535) : SW'(0));
            quo    = biased[SW-1:16];
            if (quo > OUT_HI) begin
                m_tdata_next[r*COORD_BITS +: COORD_BITS] = OUT_HI[COORD_BITS-1:0];
            end else if (quo < OUT_LO) begin
                m_tdata_next[r*COORD_BITS +: COORD_BITS] = OUT_LO[COORD_BITS-1:0];
            end else begin
                m_tdata_next[r*COORD_BITS +: COORD_BITS] = quo[COORD_BITS-1:0];
            end
        end
    end

    // Advance stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg       <= s_accept;
            v2_reg       <= v1_reg;
            m_tvalid_reg <= v2_reg;
        end
    end

    // Load stage payloads
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int c = 0; c < 3; c++) begin
                d_reg[c] <= d_next[c];
            end
        end
        if (adv && v1_reg) begin
            for (int i = 0; i < NCOEF; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (adv && v2_reg) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/epr_matrix.sv
// ----------------------------------------------------------------------------
// Euler point rotator coefficient builder
// Evaluates sine and cosine of the three angles on one shared 32x32
// multiplier, then forms and holds the nine z-y-x rotation coefficients.
// ----------------------------------------------------------------------------
module epr_matrix #(
    parameter int ANGLE_BITS = epr_pkg::ANGLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    restart,
    input  logic [ANGLE_BITS-1:0]   yaw,
    input  logic [ANGLE_BITS-1:0]   pitch,
    input  logic [ANGLE_BITS-1:0]   roll,
    output logic                    busy,
    output epr_pkg::coef_mat_t      coef
);
    import epr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_T2   = 4'd2;
    localparam logic [3:0] ST_HMUL = 4'd3;
    localparam logic [3:0] ST_HADD = 4'd4;
    localparam logic [3:0] ST_FMUL = 4'd5;
    localparam logic [3:0] ST_FIN  = 4'd6;
    localparam logic [3:0] ST_MAT1 = 4'd7;
    localparam logic [3:0] ST_MAT2 = 4'd8;
    localparam logic [3:0] ST_MAT3 = 4'd9;

    localparam int PAD_W = 32 - ANGLE_BITS;
    localparam int T_W   = 30;
    localparam int Q_W   = 17;
    localparam logic [T_W:0]  Q30       = 31'h4000_0000;
    localparam logic [2:0]    LAST_EVAL = 3'd5;
    localparam logic [Q_W-1:0] Q_ONE    = 17'h10000;

    typedef logic signed [COEF_W:0] wcoef_t;
    typedef struct packed {
        coef_t s;
        coef_t c;
    } sc_t;

    // Sequencer state
    logic [3:0]          state_reg;
    logic [2:0]          eval_reg;
    logic [1:0]          k_reg;

    // Polynomial datapath
    logic signed [31:0]  t2_reg;
    logic signed [31:0]  acc_reg;
    logic signed [63:0]  prod_reg;
    logic [Q_W-1:0]      qs_reg [6];

    // Coefficient products
    coef_t cacb_reg, casb_reg, sacg_reg, sacb_reg, sasb_reg;
    coef_t cacg_reg, casg_reg, sasg_reg, cbsg_reg, cbcg_reg;
    coef_t casb_sg_reg, casb_cg_reg, sasb_sg_reg, sasb_cg_reg;
    coef_mat_t coef_reg;

    logic [ANGLE_BITS-1:0] ang;
    logic [T_W-1:0]        t_frac;
    logic [T_W:0]          x_val;
    logic signed [31:0]    x_op;
    logic signed [31:0]    mul_a;
    logic signed [31:0]    mul_b;
    logic signed [63:0]    prod_bias;
    logic signed [31:0]    prod_q;
    logic signed [32:0]    fin_round;
    logic [Q_W-1:0]        fin_val;
    sc_t                   sc_a;
    sc_t                   sc_b;
    sc_t                   sc_g;

    // Product of two Q1.16 values, truncated toward zero
    function automatic coef_t m16(input coef_t a, input coef_t b);
        logic signed [2*COEF_W-1:0] p;
        logic signed [2*COEF_W-1:0] pb;
        p  = a * b;
        pb = p + (p[2*COEF_W-1] ? 36'sd65535 : 36'sd0);
        return pb[COEF_W+15:16];
    endfunction

    // Clamp a sum to the coefficient range
    function automatic coef_t sat_coef(input wcoef_t v);
        coef_t r;
        if (v[COEF_W] != v[COEF_W-1]) begin
            r = v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

    // Quadrant symmetry: pick sine and cosine from the two quarter values
    function automatic sc_t map_quad(input logic [1:0] q, input logic [Q_W-1:0] up,
                                     input logic [Q_W-1:0] dn);
        sc_t   r;
        coef_t u;
        coef_t d;
        u = coef_t'({1'b0, up});
        d = coef_t'({1'b0, dn});
        unique case (q)
            2'd0: begin r.s = u;  r.c = d;  end
            2'd1: begin r.s = d;  r.c = -u; end
            2'd2: begin r.s = -u; r.c = -d; end
            2'd3: begin r.s = -d; r.c = u;  end
        endcase
        return r;
    endfunction

    // Select the angle under evaluation and its quarter-turn fraction
    always_comb begin
        unique case (eval_reg[2:1])
            2'd0:    ang = yaw;
            2'd1:    ang = pitch;
            default: ang = roll;
        endcase
        t_frac = {ang[ANGLE_BITS-3:0], {PAD_W{1'b0}}};
        x_val  = eval_reg[0] ? (Q30 - {1'b0, t_frac}) : {1'b0, t_frac};
        x_op   = $signed({1'b0, x_val});
    end

    // Route the shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_SQ: begin
                mul_a = x_op;
                mul_b = x_op;
            end
            ST_HMUL: begin
                mul_a = acc_reg;
                mul_b = t2_reg;
            end
            default: begin
                mul_a = acc_reg;
                mul_b = x_op;
            end
        endcase
    end

    // Drop 30 fraction bits, truncating toward zero
    assign prod_bias = prod_reg + (prod_reg[63] ? 64'sd1073741823 : 64'sd0);
    assign prod_q    = prod_bias[61:30];

    // Round Q2.30 to Q1.16 and clamp to 0..1
    always_comb begin
        fin_round = {prod_q[31], prod_q} + 33'sd8192;
        if (fin_round[32]) begin
            fin_val = '0;
        end else if (fin_round[31:14] > {1'b0, Q_ONE}) begin
            fin_val = Q_ONE;
        end else begin
            fin_val = fin_round[30:14];
        end
    end

    assign sc_a = map_quad(yaw[ANGLE_BITS-1:ANGLE_BITS-2], qs_reg[0], qs_reg[1]);
    assign sc_b = map_quad(pitch[ANGLE_BITS-1:ANGLE_BITS-2], qs_reg[2], qs_reg[3]);
    assign sc_g = map_quad(roll[ANGLE_BITS-1:ANGLE_BITS-2], qs_reg[4], qs_reg[5]);

    // Register every multiplier product
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequence the six quarter sines and the three coefficient steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SQ;
            eval_reg  <= '0;
            for (int i = 0; i < NCOEF; i++) begin
                coef_reg[i] <= ((i % 4) == 0) ? COEF_ONE : '0;
            end
        end else if (restart) begin
            state_reg <= ST_SQ;
            eval_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_SQ: begin
                    state_reg <= ST_T2;
                end
                ST_T2: begin
                    t2_reg    <= prod_q;
                    acc_reg   <= K9;
                    k_reg     <= '0;
                    state_reg <= ST_HMUL;
                end
                ST_HMUL: begin
                    state_reg <= ST_HADD;
                end
                ST_HADD: begin
                    acc_reg   <= horner_k(k_reg) + prod_q;
                    k_reg     <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? ST_FMUL : ST_HMUL;
                end
                ST_FMUL: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    qs_reg[eval_reg] <= fin_val;
                    if (eval_reg == LAST_EVAL) begin
                        state_reg <= ST_MAT1;
                    end else begin
                        eval_reg  <= eval_reg + 3'd1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_MAT1: begin
                    cacb_reg  <= m16(sc_a.c, sc_b.c);
                    casb_reg  <= m16(sc_a.c, sc_b.s);
                    sacg_reg  <= m16(sc_a.s, sc_g.c);
                    sacb_reg  <= m16(sc_a.s, sc_b.c);
                    sasb_reg  <= m16(sc_a.s, sc_b.s);
                    cacg_reg  <= m16(sc_a.c, sc_g.c);
                    casg_reg  <= m16(sc_a.c, sc_g.s);
                    sasg_reg  <= m16(sc_a.s, sc_g.s);
                    cbsg_reg  <= m16(sc_b.c, sc_g.s);
                    cbcg_reg  <= m16(sc_b.c, sc_g.c);
                    state_reg <= ST_MAT2;
                end
                ST_MAT2: begin
                    casb_sg_reg <= m16(casb_reg, sc_g.s);
                    casb_cg_reg <= m16(casb_reg, sc_g.c);
                    sasb_sg_reg <= m16(sasb_reg, sc_g.s);
                    sasb_cg_reg <= m16(sasb_reg, sc_g.c);
                    state_reg   <= ST_MAT3;
                end
                ST_MAT3: begin
                    coef_reg[0] <= cacb_reg;
                    coef_reg[1] <= sat_coef(wcoef_t'(casb_sg_reg) - wcoef_t'(sacg_reg));
                    coef_reg[2] <= sat_coef(wcoef_t'(casb_cg_reg) + wcoef_t'(sasg_reg));
                    coef_reg[3] <= sacb_reg;
                    coef_reg[4] <= sat_coef(wcoef_t'(sasb_sg_reg) + wcoef_t'(cacg_reg));
                    coef_reg[5] <= sat_coef(wcoef_t'(sasb_cg_reg) - wcoef_t'(casg_reg));
                    coef_reg[6] <= sat_coef(wcoef_t'(0) - wcoef_t'(sc_b.s));
                    coef_reg[7] <= cbsg_reg;
                    coef_reg[8] <= cbcg_reg;
                    state_reg   <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign coef = coef_reg;

endmodule

>>> rtl/epr_checker.sv
// ----------------------------------------------------------------------------
// Euler point rotator checker
// Port-level checks of the output handshake, reset and coefficient rebuild.
// ----------------------------------------------------------------------------
`include "euler_point_rotator_defines.svh"

module epr_checker #(
    parameter int TDW = 48
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [TDW-1:0]              m_tdata,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [epr_pkg::IDX_W-1:0]   cfg_index
);
    import epr_pkg::*;

    logic angle_wr;

    // Flag an accepted write to one of the angle registers
    assign angle_wr = cfg_valid && cfg_ready &&
                      (cfg_index == REG_YAW || cfg_index == REG_PITCH ||
                       cfg_index == REG_ROLL);

    // A waiting result stays offered
    `EPR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // A waiting result keeps its value
    `EPR_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))

    // Reset empties the pipeline and starts a coefficient rebuild
    `EPR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && !s_tready)

    // An angle write blocks input until the coefficients are rebuilt
    `EPR_ASSERT(a_angle_rebuild, aclk, aresetn, angle_wr |=> !s_tready)

endmodule

bind euler_point_rotator epr_checker #(
    .TDW (TDW)
) u_epr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

>>> tb/euler_point_rotator_checker.sv
// ----------------------------------------------------------------------------
// Euler point rotator checker
// Watches the configuration, point and result channels of the rotator. It
// keeps its own copy of the registers and of the nine Q1.16 coefficients,
// predicts the rotated point for every accepted input beat and compares each
// result beat, coordinate by coordinate, with the oldest prediction.
// ----------------------------------------------------------------------------
module euler_point_rotator_checker #(
    parameter int COORD_BITS = epr_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = epr_pkg::ANGLE_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    input  logic                                       s_tready,
    // point_x, point_y, point_z, zero pad
    input  logic [epr_pkg::tdata_w(COORD_BITS)-1:0]    s_tdata,
    input  logic                                       m_tvalid,
    input  logic                                       m_tready,
    // rotated_x, rotated_y, rotated_z, zero pad
    input  logic [epr_pkg::tdata_w(COORD_BITS)-1:0]    m_tdata,
    input  logic                                       cfg_valid,
    input  logic                                       cfg_ready,
    input  logic [epr_pkg::IDX_W-1:0]                  cfg_index,
    input  logic [epr_pkg::cfg_w(ANGLE_BITS)-1:0]      cfg_data,
    output int                                         mismatches,
    output int                                         waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CFG_W     = epr_pkg::cfg_w(ANGLE_BITS);
    localparam longint Q30       = 1073741824;
    localparam longint Q16       = 65536;
    localparam longint COEF_MAX  = 131071;
    localparam longint COEF_MIN  = -131072;
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int     MAX_LINES = 100;

    // Odd Taylor terms of the quarter-turn sine, Q2.30
    localparam longint SIN_T1 = 1686629713;
    localparam longint SIN_T3 = -693598671;
    localparam longint SIN_T5 = 85569278;
    localparam longint SIN_T7 = -5027044;
    localparam longint SIN_T9 = 172272;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    // x sits in the lowest bits of a beat
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    // Shadow registers and coefficient cache
    logic [epr_pkg::ZOOM_W-1:0] grid_zoom;
    logic [epr_pkg::SIZE_W-1:0] map_cols;
    logic [epr_pkg::SIZE_W-1:0] map_rows;
    logic [ANGLE_BITS-1:0]      yaw;
    logic [ANGLE_BITS-1:0]      pitch;
    logic [ANGLE_BITS-1:0]      roll;
    longint                     rot_coef [9];

    point_t rotated_q [$];
    point_t got;
    point_t want;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint mul_q16(input longint a, input longint b);
        return (a * b) / Q16;
    endfunction

    // Sine over a quarter turn, t in Q2.30, Horner form truncated at each step
    function automatic longint quarter_sine(input longint t);
        longint t2;
        longint acc;
        t2  = (t * t) / Q30;
        acc = SIN_T9;
        acc = SIN_T7 + (acc * t2) / Q30;
        acc = SIN_T5 + (acc * t2) / Q30;
        acc = SIN_T3 + (acc * t2) / Q30;
        acc = SIN_T1 + (acc * t2) / Q30;
        acc = (acc * t) / Q30;
        return clamp((acc + 8192) / 16384, 0, Q16);
    endfunction

    // Fold the angle into one quadrant and pick sign and sin/cos from it
    task automatic angle_sin_cos(input logic [ANGLE_BITS-1:0] ang,
                                 output longint s, output longint c);
        logic [1:0] quad;
        longint     t;
        longint     up;
        longint     dn;
        quad = ang[ANGLE_BITS-1 -: 2];
        t    = longint'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
        up   = quarter_sine(t);
        dn   = quarter_sine(Q30 - t);
        case (quad)
            2'd0: begin s = up;  c = dn;  end
            2'd1: begin s = dn;  c = -up; end
            2'd2: begin s = -up; c = -dn; end
            default: begin s = -dn; c = up; end
        endcase
    endtask

    // Rebuild the z-y-x matrix, row major, each entry held to 18 bits
    task automatic rebuild_matrix();
        longint sa, ca, sb, cb, sg, cg;
        angle_sin_cos(yaw, sa, ca);
        angle_sin_cos(pitch, sb, cb);
        angle_sin_cos(roll, sg, cg);
        rot_coef[0] = clamp(mul_q16(ca, cb), COEF_MIN, COEF_MAX);
        rot_coef[1] = clamp(mul_q16(mul_q16(ca, sb), sg) - mul_q16(sa, cg),
                            COEF_MIN, COEF_MAX);
        rot_coef[2] = clamp(mul_q16(mul_q16(ca, sb), cg) + mul_q16(sa, sg),
                            COEF_MIN, COEF_MAX);
        rot_coef[3] = clamp(mul_q16(sa, cb), COEF_MIN, COEF_MAX);
        rot_coef[4] = clamp(mul_q16(mul_q16(sa, sb), sg) + mul_q16(ca, cg),
                            COEF_MIN, COEF_MAX);
        rot_coef[5] = clamp(mul_q16(mul_q16(sa, sb), cg) - mul_q16(ca, sg),
                            COEF_MIN, COEF_MAX);
        rot_coef[6] = clamp(-sb, COEF_MIN, COEF_MAX);
        rot_coef[7] = clamp(mul_q16(cb, sg), COEF_MIN, COEF_MAX);
        rot_coef[8] = clamp(mul_q16(cb, cg), COEF_MIN, COEF_MAX);
    endtask

    task automatic apply_write(input logic [epr_pkg::IDX_W-1:0] idx,
                               input logic [CFG_W-1:0] data);
        case (idx)
            epr_pkg::REG_ZOOM:   grid_zoom  = data[epr_pkg::ZOOM_W-1:0];
            epr_pkg::REG_WIDTH:  map_cols   = data[epr_pkg::SIZE_W-1:0];
            epr_pkg::REG_HEIGHT: map_rows   = data[epr_pkg::SIZE_W-1:0];
            epr_pkg::REG_YAW:    begin yaw   = data[ANGLE_BITS-1:0]; rebuild_matrix(); end
            epr_pkg::REG_PITCH:  begin pitch = data[ANGLE_BITS-1:0]; rebuild_matrix(); end
            epr_pkg::REG_ROLL:   begin roll  = data[ANGLE_BITS-1:0]; rebuild_matrix(); end
            default: ;
        endcase
    endtask

    // Grid center along one axis; an empty map counts as one cell
    function automatic longint grid_center(input logic [epr_pkg::SIZE_W-1:0] cells);
        longint n;
        n = (cells == 0) ? 1 : longint'(cells);
        return (longint'(grid_zoom) * (n - 1)) / 2;
    endfunction

    function automatic coord_t row_out(input int r, input longint dx, input longint dy,
                                       input longint dz, input longint cen);
        longint acc;
        acc = rot_coef[3*r] * dx + rot_coef[3*r+1] * dy + rot_coef[3*r+2] * dz
            + cen * Q16;
        return coord_t'(clamp(acc / Q16, COORD_MIN, COORD_MAX));
    endfunction

    function automatic point_t rotate_point(input point_t p);
        longint cx, cy, dx, dy, dz;
        point_t r;
        cx  = grid_center(map_cols);
        cy  = grid_center(map_rows);
        dx  = longint'(p.x) - cx;
        dy  = longint'(p.y) - cy;
        dz  = longint'(p.z);
        r.x = row_out(0, dx, dy, dz, cx);
        r.y = row_out(1, dx, dy, dz, cy);
        r.z = row_out(2, dx, dy, dz, 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_LINES)
            $display("ERROR %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // Track writes, score result beats, then queue the prediction for new points
    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_zoom  = 1;
            map_cols   = 1;
            map_rows   = 1;
            yaw        = '0;
            pitch      = '0;
            roll       = '0;
            rebuild_matrix();
            rotated_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                got = point_t'(m_tdata[3*COORD_BITS-1:0]);
                if (rotated_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with no point pending", m_tdata));
                end else begin
                    want = rotated_q.pop_front();
                    if (got.x !== want.x)
                        report_mismatch($sformatf("rotated_x is %0d, expected %0d",
                                                  got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("rotated_y is %0d, expected %0d",
                                                  got.y, want.y));
                    if (got.z !== want.z)
                        report_mismatch($sformatf("rotated_z is %0d, expected %0d",
                                                  got.z, want.z));
                end
            end
            if (s_tvalid && s_tready)
                rotated_q.push_back(rotate_point(point_t'(s_tdata[3*COORD_BITS-1:0])));
        end
        waiting = rotated_q.size();
    end

endmodule

>>> tb/euler_point_rotator_tb.sv
// ----------------------------------------------------------------------------
// Euler point rotator testbench
// Drives points and configuration writes into the rotator and leaves the
// scoring to the checker. A directed part covers coordinate extremes, quarter
// turns, empty and oversized maps, zero zoom, saturation and writes to unused
// register indexes; random phases follow, each with a fresh register setting
// and one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module euler_point_rotator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB           = epr_pkg::COORD_BITS_DEF;
    localparam int AB           = epr_pkg::ANGLE_BITS_DEF;
    localparam int TDATA_W      = epr_pkg::tdata_w(CB);
    localparam int CFG_W        = epr_pkg::cfg_w(AB);
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_POINTS = 225;

    // Indexes with no register behind them
    localparam logic [epr_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [epr_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [TDATA_W-1:0]          s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [TDATA_W-1:0]          m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [epr_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data  = '0;

    int mismatches;
    int waiting;
    int idle_cycles  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    euler_point_rotator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    euler_point_rotator_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    // Receiver: random stalls, or one long hold-off when requested
    initial begin
        bit hold_ack;
        hold_ack = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: end the run after too long without any beat on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Half full range, half close to the origin so that not every result saturates
    function automatic logic [CB-1:0] rand_coord();
        if ($urandom_range(1))
            return CB'($urandom_range(0, 65535));
        return CB'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    function automatic logic [CFG_W-1:0] pick_zoom();
        case ($urandom_range(3))
            0: return CFG_W'($urandom_range(0, 65535));
            1: return $urandom_range(1) ? CFG_W'(255) : CFG_W'(0);
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(3))
            0: return CFG_W'($urandom_range(0, 65535));
            1: begin
                case ($urandom_range(3))
                    0: return CFG_W'(0);
                    1: return CFG_W'(1);
                    2: return CFG_W'(1024);
                    default: return CFG_W'(2047);
                endcase
            end
            default: return CFG_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Offer one point beat, with random gaps ahead of it; valid stays high after
    task automatic send_point(input logic [CB-1:0] px, input logic [CB-1:0] py,
                              input logic [CB-1:0] pz);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({pz, py, px});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait for every predicted result to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [epr_pkg::IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write all six registers in index order, optionally poking the unused indexes
    task automatic program_regs(input logic [CFG_W-1:0] zoom, input logic [CFG_W-1:0] cols,
                                input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] yaw,
                                input logic [CFG_W-1:0] pitch, input logic [CFG_W-1:0] roll,
                                input bit spare);
        write_reg(epr_pkg::REG_ZOOM, zoom);
        write_reg(epr_pkg::REG_WIDTH, cols);
        write_reg(epr_pkg::REG_HEIGHT, rows);
        write_reg(epr_pkg::REG_YAW, yaw);
        write_reg(epr_pkg::REG_PITCH, pitch);
        write_reg(epr_pkg::REG_ROLL, roll);
        if (spare) begin
            write_reg(REG_SPARE_LO, CFG_W'($urandom_range(0, 65535)));
            write_reg(REG_SPARE_HI, '1);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        idle_mode_t mode;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Identity matrix after reset: extremes and alternating bit patterns
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h8000, 16'h0001);
        send_point(16'h8000, 16'h7FFF, 16'hFFFF);
        send_point(16'h5555, 16'hAAAA, 16'h7FFF);
        send_point(16'hAAAA, 16'h5555, 16'h8000);
        drain_results();

        // Largest zoom, 1024-cell maps: center far out of range, rotated_x saturates
        program_regs(255, 1024, 1024, 8192, 0, 0, 1'b0);
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 16'h8000);
        drain_results();

        // Zero zoom, empty width, oversized height, quarter turns, unused indexes
        program_regs(0, 0, 2047, 16384, 32768, 49152, 1'b1);
        send_point(16'd100, -16'sd200, 16'd300);
        send_point(16'h7FFF, 16'h8000, 16'h7FFF);
        send_point(16'h8000, 16'h0000, 16'h0001);
        drain_results();

        // Angles just short of a full turn, oversized width, empty height
        program_regs(7, 2047, 0, 65535, 65535, 65535, 1'b0);
        send_point(16'h0010, 16'hFFF0, 16'h0100);
        send_point(16'h7FFF, 16'h7FFF, 16'h8000);
        send_point(16'h8000, 16'h8000, 16'h7FFF);
        drain_results();

        // Small map and oblique angles: no saturation expected except at the rim
        program_regs(1, 3, 5, 10923, 5461, 60000, 1'b0);
        send_point(16'd1, 16'd2, 16'd3);
        send_point(-16'sd5, 16'd7, -16'sd9);
        send_point(16'd23170, 16'd23170, 16'd0);
        drain_results();

        // Random phases, each with its own setting and one of four idling patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            mode = idle_mode_t'(phase % 4);
            case (mode)
                IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                IDLE_SENDER:   begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default:       begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            program_regs(pick_zoom(), pick_size(), pick_size(),
                         CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                         CFG_W'($urandom_range(0, 65535)), $urandom_range(3) == 0);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                // Long receiver hold-off while points keep coming
                if (phase == 4 && n == 10)
                    hold_req = !hold_req;
                send_point(rand_coord(), rand_coord(), rand_coord());
                if ($urandom_range(99) == 0)
                    drain_results();
            end
            drain_results();
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
